### sv/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

   // word geometry of the used-page bitmap
   localparam int WORD_BITS = 64;
   localparam int BIT_W = 6;
   localparam int IDX_W = BIT_W + 1;

   // field widths
   localparam int CW = 13;
   localparam int FRAME_BITS = 20;
   localparam int FW1 = FRAME_BITS + 1;
   localparam int WIDX_W = CW - BIT_W;
   localparam int PAGE_CAP = 8191;
   localparam int MAX_PAGES_DEF = 4096;
   localparam int NWORDS_DEF = 64;
   localparam int ADDR_W_DEF = 6;
   localparam logic [FW1-1:0] FRAME_SPACE = FW1'(1 << FRAME_BITS);
   localparam logic [CW-1:0] REGION_RESET = CW'(4096);

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = FRAME_BITS;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_PAGES = 1'b1;

   // command codes
   localparam logic [2:0] CMD_ALLOC_ONE = 3'd0;
   localparam logic [2:0] CMD_ALLOC_RUN = 3'd1;
   localparam logic [2:0] CMD_FREE = 3'd2;
   localparam logic [2:0] CMD_RESERVE = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_OUTSIDE = 3'd2;
   localparam logic [2:0] ST_BEYOND = 3'd3;
   localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;
   localparam logic [2:0] ST_ZERO_COUNT = 3'd5;

   typedef struct packed {
      logic [2:0]            command;
      logic [FRAME_BITS-1:0] frame_number;
      logic [CW-1:0]         run_length;
      logic [FRAME_BITS:0]   end_frame;
   } bpa_req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [FRAME_BITS-1:0] result_frame;
      logic                  page_used;
      logic [CW-1:0]         free_count;
   } bpa_rsp_type;

   // controls of the per-word datapath
   typedef struct packed {
      logic [WIDX_W-1:0] word;
      logic [CW-1:0]     range_s;
      logic [CW-1:0]     range_e;
      logic [CW-1:0]     eff_pages;
      logic [CW-1:0]     run_length;
      logic [CW:0]       carry;
   } wl_ctl_type;

   typedef struct packed {
      logic                 avail_any;
      logic [BIT_W-1:0]     avail_bit;
      logic [WORD_BITS-1:0] range_mask;
      logic                 cover_ok;
      logic [IDX_W-1:0]     new_count;
      logic                 run_found;
      logic [BIT_W-1:0]     run_end_bit;
      logic [CW:0]          carry_next;
   } wl_out_type;

   // index of the lowest set bit, WORD_BITS when none
   function automatic logic [IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(WORD_BITS);
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (v[b]) idx = IDX_W'(b);
      end
      return idx;
   endfunction

   // index of the highest set bit, WORD_BITS when none
   function automatic logic [IDX_W-1:0] highest_set(input logic [WORD_BITS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(WORD_BITS);
      for (int b = 0; b < WORD_BITS; b++) begin
         if (v[b]) idx = IDX_W'(b);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

### sv/bpa_bitmap_ram.sv
`default_nettype none

module bpa_bitmap_ram #(
   parameter int DEPTH = bpa_pkg::NWORDS_DEF,
   parameter int AW = bpa_pkg::ADDR_W_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [AW-1:0]                  waddr,
   input  wire logic [bpa_pkg::WORD_BITS-1:0]  wdata,
   input  wire logic [AW-1:0]                  raddr,
   output logic [bpa_pkg::WORD_BITS-1:0]       rdata
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/bpa_word_logic.sv
`default_nettype none

module bpa_word_logic (
   input  wire logic [bpa_pkg::WORD_BITS-1:0] rd_data,
   input  wire bpa_pkg::wl_ctl_type           ctl,
   output bpa_pkg::wl_out_type                res
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] ones, vmask, free_v, lo_mask, hi_mask, rmask;
   logic [WORD_BITS-1:0] p, acc, win, hitvec, cand;
   logic [WIDX_W-1:0]    full_w;
   logic [BIT_W-1:0]     part;
   logic [IDX_W-1:0]     av_idx, first_used, top_used, cand_idx;
   logic [CW-1:0]        bc;
   logic                 carry_hit;
   logic                 run_seen;

   assign ones = '1;

   // pages of this word that lie inside the region
   always_comb begin
      full_w = ctl.eff_pages[CW-1:BIT_W];
      part = ctl.eff_pages[BIT_W-1:0];
      if (ctl.word < full_w) begin
         vmask = ones;
      end else if (ctl.word == full_w) begin
         vmask = ~(ones << part);
      end else begin
         vmask = '0;
      end
   end

   // bits of this word inside the page range
   always_comb begin
      lo_mask = (ctl.word == ctl.range_s[CW-1:BIT_W]) ?
                (ones << ctl.range_s[BIT_W-1:0]) : ones;
      hi_mask = (ctl.word == ctl.range_e[CW-1:BIT_W]) ?
                (ones >> (BIT_W'(WORD_BITS - 1) - ctl.range_e[BIT_W-1:0])) : ones;
      rmask = lo_mask & hi_mask;
   end

   assign free_v = ~rd_data & vmask;
   assign av_idx = lowest_set(free_v);

   // windows of run_length free pages ending at each bit, by doubling
   always_comb begin
      p = free_v;
      acc = ones;
      run_seen = 1'b0;
      for (int i = 0; i <= BIT_W; i++) begin
         if (ctl.run_length[i]) begin
            acc = run_seen ? (p & (acc << (1 << i))) : p;
            run_seen = 1'b1;
         end
         p = p & (p << (1 << i));
      end
      if (|ctl.run_length[CW-1:BIT_W+1]) acc = '0;
      win = acc;
   end

   // a run carried in from lower words that completes in the low free bits
   always_comb begin
      first_used = lowest_set(~free_v);
      bc = ctl.run_length - ctl.carry[CW-1:0] - CW'(1);
      carry_hit = (ctl.carry != '0) && (ctl.carry < {1'b0, ctl.run_length}) &&
                  (bc[CW-1:BIT_W] == '0) && ({1'b0, bc[BIT_W-1:0]} < first_used);
      hitvec = carry_hit ? (WORD_BITS'(1) << bc[BIT_W-1:0]) : '0;
      cand = win | hitvec;
      cand_idx = lowest_set(cand);
      top_used = highest_set(~free_v);
   end

   always_comb begin
      res.avail_any = |free_v;
      res.avail_bit = av_idx[BIT_W-1:0];
      res.range_mask = rmask;
      res.cover_ok = ((rd_data & rmask) == rmask);
      res.new_count = IDX_W'($countones(rmask & ~rd_data));
      res.run_found = |cand;
      res.run_end_bit = cand_idx[BIT_W-1:0];
      if (&free_v) begin
         res.carry_next = ctl.carry + (CW+1)'(WORD_BITS);
      end else begin
         res.carry_next = (CW+1)'(BIT_W'(WORD_BITS - 1) - top_used[BIT_W-1:0]);
      end
   end

endmodule

`default_nettype wire

### sv/bitmap_page_allocator.sv
`default_nettype none

// Page frame allocator for one region, with a used-page bitmap in a RAM.
// Commands come on start/req_data and are taken when start is high and busy
// is low. Each command gives exactly one response: rsp_valid is high for one
// cycle with rsp_data, and the receiver cannot hold it off.
// Configuration: csr_we with csr_index (0 base frame, 1 region pages) and
// csr_wdata, written while idle. A write clears the bitmap and hint.
// Sequence: the command is taken, then decoded, then the bitmap is
// walked one 64-bit word per cycle through the registered RAM read port.
// Commands decided from the range check alone answer from the decode step.
// Alloc one reads up to every word of the region (64 for a full region),
// from the hint word on. Alloc run reads up to every word when no gap
// fits; a found run then walks the words of its span again for marking.
// Free walks its span twice (check then clear); reserve and query walk
// it once.
// After reset and after each configuration write a clearing pass writes
// every RAM word, one per cycle, with busy high; configuration writes are
// still taken during it.
// A new command is taken in the cycle its predecessor's response is shown.
module bitmap_page_allocator #(
   parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire bpa_pkg::bpa_req_type              req_data,
   output logic                                   rsp_valid,
   output bpa_pkg::bpa_rsp_type                   rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpa_pkg::*;

   localparam int EFF_MAX = (MAX_PAGES < PAGE_CAP) ? MAX_PAGES : PAGE_CAP;
   localparam int NWORDS = (EFF_MAX + WORD_BITS - 1) / WORD_BITS;
   localparam int WIW = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_DEC   = 10'b0000000100,
      S_ONE   = 10'b0000001000,
      S_RSCAN = 10'b0000010000,
      S_RMARK = 10'b0000100000,
      S_FCHK  = 10'b0001000000,
      S_FCLR  = 10'b0010000000,
      S_RSV   = 10'b0100000000,
      S_QRY   = 10'b1000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [FRAME_BITS-1:0] base_ff, base_in;
   logic [CW-1:0]         region_ff, region_in;
   logic [CW-1:0]         eff_ff, eff_in;
   logic [WIW:0]          nw_ff, nw_in;
   logic [CW-1:0]         free_ff, free_in;
   logic [CW-1:0]         hint_ff, hint_in;
   bpa_req_type           req_ff, req_in;
   logic [CW-1:0]         range_s_ff, range_s_in, range_e_ff, range_e_in;
   logic [CW:0]           carry_ff, carry_in;
   logic [WIW-1:0]        iss_w_ff, iss_w_in;
   logic [WIW:0]          iss_cnt_ff, iss_cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [WIW-1:0]        rd_w_ff, rd_w_in;
   logic                  rd_last_ff, rd_last_in;
   logic [WIW-1:0]        clr_w_ff, clr_w_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   bpa_rsp_type           rsp_ff, rsp_in;

   logic                  mem_we;
   logic [WIW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;
   wl_ctl_type            wl_ctl;
   wl_out_type            wl_res;

   logic [CW-1:0]         eff_calc;
   logic [FW1-1:0]        room;
   logic [CW:0]           nw_sum;
   logic [FRAME_BITS-1:0] off, rsv_lo;
   logic                  in_region, beyond, rsv_empty;
   logic [CW:0]           free_end;
   logic [FW1-1:0]        region_end, rsv_hi;
   logic [CW-1:0]         rsv_s, rsv_e, page, end_p;
   logic [WIW:0]          iss_nxt;
   logic                  fin, rng_go;
   logic [2:0]            fin_status;
   logic [FRAME_BITS-1:0] fin_frame;
   logic                  fin_used;

   function automatic logic [WIW-1:0] word_of(input logic [CW-1:0] pg);
      return WIW'(pg[CW-1:BIT_W]);
   endfunction

   bpa_bitmap_ram #(
      .DEPTH (NWORDS),
      .AW    (WIW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (iss_w_ff),
      .rdata (mem_rdata)
   );

   assign wl_ctl.word = WIDX_W'(rd_w_ff);
   assign wl_ctl.range_s = range_s_ff;
   assign wl_ctl.range_e = range_e_ff;
   assign wl_ctl.eff_pages = eff_ff;
   assign wl_ctl.run_length = req_ff.run_length;
   assign wl_ctl.carry = carry_ff;

   bpa_word_logic u_word (
      .rd_data (mem_rdata),
      .ctl     (wl_ctl),
      .res     (wl_res)
   );

   // effective page count from the configuration
   always_comb begin
      room = FRAME_SPACE - {1'b0, base_ff};
      eff_calc = region_ff;
      if (region_ff > CW'(EFF_MAX)) eff_calc = CW'(EFF_MAX);
      if (FW1'(eff_calc) > room) eff_calc = room[CW-1:0];
      nw_sum = {1'b0, eff_calc} + (CW+1)'(WORD_BITS - 1);
   end

   // range checks of the held transaction
   always_comb begin
      off = req_ff.frame_number - base_ff;
      in_region = (req_ff.frame_number >= base_ff) && (off < FRAME_BITS'(eff_ff));
      free_end = {1'b0, off[CW-1:0]} + {1'b0, req_ff.run_length};
      beyond = free_end > {1'b0, eff_ff};
      rsv_lo = (req_ff.frame_number > base_ff) ? req_ff.frame_number : base_ff;
      region_end = {1'b0, base_ff} + FW1'(eff_ff);
      rsv_hi = (req_ff.end_frame < region_end) ? req_ff.end_frame : region_end;
      rsv_empty = {1'b0, rsv_lo} >= rsv_hi;
      rsv_s = CW'(rsv_lo - base_ff);
      rsv_e = CW'(rsv_hi - {1'b0, base_ff} - FW1'(1));
      page = CW'({rd_w_ff, wl_res.avail_bit});
      end_p = CW'({rd_w_ff, wl_res.run_end_bit});
      iss_nxt = {1'b0, iss_w_ff} + (WIW+1)'(1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      region_in = region_ff;
      eff_in = eff_ff;
      nw_in = nw_ff;
      free_in = free_ff;
      hint_in = hint_ff;
      req_in = req_ff;
      range_s_in = range_s_ff;
      range_e_in = range_e_ff;
      carry_in = carry_ff;
      clr_w_in = clr_w_ff;
      rsp_vld_in = 1'b0;
      rsp_in = rsp_ff;
      mem_we = 1'b0;
      mem_waddr = rd_w_ff;
      mem_wdata = mem_rdata;
      fin = 1'b0;
      fin_status = ST_OK;
      fin_frame = '0;
      fin_used = 1'b0;
      rng_go = 1'b0;

      // read issue, one word per cycle
      if (iss_cnt_ff != '0) begin
         iss_cnt_in = iss_cnt_ff - (WIW+1)'(1);
         iss_w_in = (iss_nxt == nw_ff) ? '0 : iss_nxt[WIW-1:0];
         rd_vld_in = 1'b1;
         rd_w_in = iss_w_ff;
         rd_last_in = (iss_cnt_ff == (WIW+1)'(1));
      end else begin
         iss_cnt_in = '0;
         iss_w_in = iss_w_ff;
         rd_vld_in = 1'b0;
         rd_w_in = rd_w_ff;
         rd_last_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_w_ff;
            mem_wdata = '0;
            eff_in = eff_calc;
            free_in = eff_calc;
            nw_in = (WIW+1)'(nw_sum[CW:BIT_W]);
            hint_in = '0;
            if (clr_w_ff == WIW'(NWORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_w_in = clr_w_ff + WIW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (req_ff.command)
               CMD_ALLOC_ONE: begin
                  if (eff_ff == '0) begin
                     fin = 1'b1;
                     fin_status = ST_NO_SPACE;
                  end else begin
                     state_in = S_ONE;
                     iss_w_in = word_of(hint_ff);
                     iss_cnt_in = nw_ff;
                     rd_vld_in = 1'b0;
                  end
               end
               CMD_ALLOC_RUN: begin
                  if (req_ff.run_length == '0) begin
                     fin = 1'b1;
                     fin_status = ST_ZERO_COUNT;
                  end else if (req_ff.run_length > eff_ff) begin
                     fin = 1'b1;
                     fin_status = ST_NO_SPACE;
                  end else begin
                     state_in = S_RSCAN;
                     carry_in = '0;
                     iss_w_in = '0;
                     iss_cnt_in = nw_ff;
                     rd_vld_in = 1'b0;
                  end
               end
               CMD_FREE: begin
                  if (req_ff.run_length == '0) begin
                     fin = 1'b1;
                     fin_status = ST_ZERO_COUNT;
                  end else if (!in_region) begin
                     fin = 1'b1;
                     fin_status = ST_OUTSIDE;
                  end else if (beyond) begin
                     fin = 1'b1;
                     fin_status = ST_BEYOND;
                  end else begin
                     state_in = S_FCHK;
                     range_s_in = off[CW-1:0];
                     range_e_in = free_end[CW-1:0] - CW'(1);
                     rng_go = 1'b1;
                  end
               end
               CMD_RESERVE: begin
                  if (rsv_empty) begin
                     fin = 1'b1;
                  end else begin
                     state_in = S_RSV;
                     range_s_in = rsv_s;
                     range_e_in = rsv_e;
                     rng_go = 1'b1;
                  end
               end
               CMD_QUERY: begin
                  if (!in_region) begin
                     fin = 1'b1;
                  end else begin
                     state_in = S_QRY;
                     range_s_in = off[CW-1:0];
                     range_e_in = off[CW-1:0];
                     rng_go = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         S_ONE: begin
            if (rd_vld_ff) begin
               if (wl_res.avail_any) begin
                  mem_we = 1'b1;
                  mem_wdata = mem_rdata | (WORD_BITS'(1) << wl_res.avail_bit);
                  hint_in = page;
                  free_in = free_ff - CW'(1);
                  fin = 1'b1;
                  fin_frame = base_ff + FRAME_BITS'(page);
               end else if (rd_last_ff) begin
                  fin = 1'b1;
                  fin_status = ST_NO_SPACE;
               end
            end
         end
         S_RSCAN: begin
            if (rd_vld_ff) begin
               if (wl_res.run_found) begin
                  state_in = S_RMARK;
                  range_s_in = end_p - req_ff.run_length + CW'(1);
                  range_e_in = end_p;
                  rng_go = 1'b1;
               end else if (rd_last_ff) begin
                  fin = 1'b1;
                  fin_status = ST_NO_SPACE;
               end else begin
                  carry_in = wl_res.carry_next;
               end
            end
         end
         S_RMARK: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wdata = mem_rdata | wl_res.range_mask;
               if (rd_last_ff) begin
                  free_in = free_ff - req_ff.run_length;
                  fin = 1'b1;
                  fin_frame = base_ff + FRAME_BITS'(range_s_ff);
               end
            end
         end
         S_FCHK: begin
            if (rd_vld_ff) begin
               if (!wl_res.cover_ok) begin
                  fin = 1'b1;
                  fin_status = ST_DOUBLE_FREE;
               end else if (rd_last_ff) begin
                  state_in = S_FCLR;
                  rng_go = 1'b1;
               end
            end
         end
         S_FCLR: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wdata = mem_rdata & ~wl_res.range_mask;
               if (rd_last_ff) begin
                  free_in = free_ff + req_ff.run_length;
                  if (range_s_ff < hint_ff) hint_in = range_s_ff;
                  fin = 1'b1;
               end
            end
         end
         S_RSV: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wdata = mem_rdata | wl_res.range_mask;
               free_in = free_ff - CW'(wl_res.new_count);
               if (rd_last_ff) fin = 1'b1;
            end
         end
         S_QRY: begin
            if (rd_vld_ff) begin
               fin = 1'b1;
               fin_used = mem_rdata[range_s_ff[BIT_W-1:0]];
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_w_in = '0;
         end
      endcase

      // start a walk over the words of the page range
      if (rng_go) begin
         iss_w_in = word_of(range_s_in);
         iss_cnt_in = {1'b0, word_of(range_e_in)} - {1'b0, word_of(range_s_in)} +
                      (WIW+1)'(1);
         rd_vld_in = 1'b0;
      end

      // response and return to idle
      if (fin) begin
         state_in = S_IDLE;
         iss_cnt_in = '0;
         rd_vld_in = 1'b0;
         rsp_vld_in = 1'b1;
         rsp_in.status = fin_status;
         rsp_in.result_frame = fin_frame;
         rsp_in.page_used = fin_used;
         rsp_in.free_count = free_in;
      end

      // configuration write restarts the clearing pass
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_FRAME: base_in = csr_wdata;
            CSR_REGION_PAGES: region_in = csr_wdata[CW-1:0];
            default: ;
         endcase
         state_in = S_CLEAR;
         clr_w_in = '0;
         iss_cnt_in = '0;
         rd_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         base_ff <= '0;
         region_ff <= REGION_RESET;
         eff_ff <= '0;
         nw_ff <= '0;
         free_ff <= '0;
         hint_ff <= '0;
         iss_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         clr_w_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         region_ff <= region_in;
         eff_ff <= eff_in;
         nw_ff <= nw_in;
         free_ff <= free_in;
         hint_ff <= hint_in;
         iss_cnt_ff <= iss_cnt_in;
         rd_vld_ff <= rd_vld_in;
         clr_w_ff <= clr_w_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      range_s_ff <= range_s_in;
      range_e_ff <= range_e_in;
      carry_ff <= carry_in;
      iss_w_ff <= iss_w_in;
      rd_w_ff <= rd_w_in;
      rd_last_ff <= rd_last_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_ff;

   // a response only follows a working cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> $past(state_ff != S_IDLE && state_ff != S_CLEAR))
      else $error("response without a transaction in progress");

   // free count never exceeds the region size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= eff_ff)
      else $error("free page count above region size");

   // the bitmap is not written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != S_IDLE)
      else $error("bitmap write while idle");

   // an accepted transaction is decoded next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !csr_we |=> state_ff == S_DEC)
      else $error("accepted transaction not decoded");

endmodule

`default_nettype wire
